[rtl/core/lookahead_confirm_latch_unit_defines.svh]
// Assertion macros used by the lookahead confirm latch checker.
`ifndef LOOKAHEAD_CONFIRM_LATCH_UNIT_DEFINES_SVH
`define LOOKAHEAD_CONFIRM_LATCH_UNIT_DEFINES_SVH

// Clocked assertion, off while reset is high.
`define LCLU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LCLU_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/lclu_pkg.sv]
// Package: sizes, cell control struct, FSM states and confirm count helper.
`timescale 1ns / 1ps
package lclu_pkg;

  localparam int Depth = 32;                    // window length (MAX_CONFIRM)
  localparam int PosW  = $clog2(Depth);         // cell position
  localparam int CntW  = $clog2(Depth + 1);     // confirm count after clamp
  localparam int CfgW  = 6;                     // config register width
  localparam int AddrW = 3;                     // two word registers
  localparam int DataW = 32;

  localparam logic [AddrW-3:0] RegRise = 1'b0;
  localparam logic [AddrW-3:0] RegFall = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic            append;     // load frame into first empty cell
    logic            shift;      // move chain one step toward cell 0
    logic            frame_bit;
    logic            ref_bit;    // value under decision (cell 0)
    logic [CntW-1:0] need;       // effective confirm count
  } cell_ctl_t;

  // Zero acts as one, large values saturate at the window length.
  function automatic logic [CntW-1:0] eff_count(input logic [CfgW-1:0] n);
    logic [CntW-1:0] r;
    if (n == '0) begin
      r = CntW'(1);
    end else if (n > CfgW'(Depth)) begin
      r = CntW'(Depth);
    end else begin
      r = CntW'(n);
    end
    return r;
  endfunction

endpackage

[rtl/core/lclu_cell.sv]
// One window cell: a held frame, its occupancy, and its confirm vote.
`timescale 1ns / 1ps
module lclu_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  lclu_pkg::cell_ctl_t     ctl,
  input  logic [lclu_pkg::PosW-1:0] pos,
  input  logic                    prev_valid,
  input  logic                    next_valid,
  input  logic                    next_bit,
  output logic                    bit_q,
  output logic                    valid,
  output logic                    ok
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= next_valid;
    end else if (ctl.append && !valid && prev_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      bit_q <= next_bit;
    end else if (ctl.append && !valid && prev_valid) begin
      bit_q <= ctl.frame_bit;
    end
  end

  // Outside the lookahead span, or held and agreeing with the candidate.
  assign ok = (lclu_pkg::CntW'(pos) >= ctl.need) || (valid && (bit_q == ctl.ref_bit));

endmodule

[rtl/core/lookahead_confirm_latch_unit.sv]
// Top level: debounce latch with lookahead confirm over a chain of cells.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in      | in        | in_valid/in_stall  | frame_bit, end_of_data
//   out     | out       | out_valid/out_stall| latched_bit, final_result
//   cfg     | in        | APB, pready tied 1 | confirm_rise/fall (6 bits)
//
// A frame that leaves the window short of full is only appended.
// A frame that fills the window is appended, then one decision is made.
// A frame with end_of_data is appended, then the window drains the frames held (up to 32),
// one decision per cycle, each waiting while the output register is stalled.
// Reset (synchronous) empties the window, clears the flag, sets both counts to 30.
// in_stall is high only in the drain state, also while a decision waits; in idle
// a waiting result does not hold off the next frame.
`timescale 1ns / 1ps
module lookahead_confirm_latch_unit (
  input  logic                          clk,
  input  logic                          rst,
  // frame stream
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          frame_bit,
  input  logic                          end_of_data,
  // decision stream
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          latched_bit,
  output logic                          final_result,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lclu_pkg::AddrW-1:0]    paddr,
  input  logic [lclu_pkg::DataW-1:0]    pwdata,
  output logic [lclu_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  localparam int D = lclu_pkg::Depth;

  // ---------------- configuration registers ----------------
  logic [lclu_pkg::CfgW-1:0] confirm_rise;
  logic [lclu_pkg::CfgW-1:0] confirm_fall;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_rise <= lclu_pkg::CfgW'(30);
      confirm_fall <= lclu_pkg::CfgW'(30);
    end else if (cfg_wr) begin
      case (paddr[lclu_pkg::AddrW-1:2])
        lclu_pkg::RegRise: confirm_rise <= pwdata[lclu_pkg::CfgW-1:0];
        lclu_pkg::RegFall: confirm_fall <= pwdata[lclu_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[lclu_pkg::AddrW-1:2])
      lclu_pkg::RegRise: prdata = lclu_pkg::DataW'(confirm_rise);
      lclu_pkg::RegFall: prdata = lclu_pkg::DataW'(confirm_fall);
      default:           prdata = '0;
    endcase
  end

  // ---------------- control state ----------------
  lclu_pkg::state_t state, state_next;
  logic             flushing, flushing_next;
  logic             latched, latched_next;
  logic             out_valid_r;
  logic             out_bit_r;
  logic             out_final_r;

  lclu_pkg::cell_ctl_t ctl;
  logic [D-1:0]        cell_bit;
  logic [D-1:0]        cell_valid;
  logic [D-1:0]        cell_ok;

  logic accept;
  logic out_free;
  logic fire;        // decision made this cycle
  logic head_bit;    // oldest held frame
  logic decision;
  logic is_final;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign head_bit = cell_bit[0];

  // A change latches only if every cell inside the confirm span agrees;
  // cells past the held frames vote no, which covers the flush tail.
  assign decision = ((head_bit != latched) && (&cell_ok)) ? head_bit : latched;
  assign is_final = flushing && !cell_valid[1];

  // new stream starts low after the final decision
  assign latched_next = fire ? (is_final ? 1'b0 : decision) : latched;

  always_comb begin
    state_next    = state;
    flushing_next = flushing;
    fire          = 1'b0;
    in_stall      = 1'b1;
    case (state)
      lclu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        // window becomes full when the last free cell takes this frame
        if (in_valid && (end_of_data || cell_valid[D-2])) begin
          state_next    = lclu_pkg::ST_DRAIN;
          flushing_next = end_of_data;
        end
      end
      lclu_pkg::ST_DRAIN: begin
        if (out_free) begin
          fire = 1'b1;
          if (!flushing || is_final) begin
            state_next    = lclu_pkg::ST_IDLE;
            flushing_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = lclu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lclu_pkg::ST_IDLE;
      flushing <= 1'b0;
      latched  <= 1'b0;
    end else begin
      state    <= state_next;
      flushing <= flushing_next;
      latched  <= latched_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_bit_r   <= decision;
      out_final_r <= is_final;
    end
  end

  assign out_valid    = out_valid_r;
  assign latched_bit  = out_bit_r;
  assign final_result = out_final_r;

  // ---------------- cell chain ----------------
  always_comb begin
    ctl.append    = accept;
    ctl.shift     = fire;
    ctl.frame_bit = frame_bit;
    ctl.ref_bit   = head_bit;
    ctl.need      = lclu_pkg::eff_count(head_bit ? confirm_rise : confirm_fall);
  end

  for (genvar k = 0; k < D; k++) begin : g_cell
    logic prev_v;
    logic next_v;
    logic next_b;
    if (k == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[k-1];
    end
    if (k == D - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_b = 1'b0;
    end else begin : g_mid
      assign next_v = cell_valid[k+1];
      assign next_b = cell_bit[k+1];
    end

    lclu_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .pos        (lclu_pkg::PosW'(k)),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_bit   (next_b),
      .bit_q      (cell_bit[k]),
      .valid      (cell_valid[k]),
      .ok         (cell_ok[k])
    );
  end

endmodule

[rtl/core/lclu_checker.sv]
// Port-level checker for the lookahead confirm latch, bound to the top level.
`timescale 1ns / 1ps
`include "lookahead_confirm_latch_unit_defines.svh"
module lclu_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic end_of_data,
  input logic out_valid,
  input logic out_stall,
  input logic latched_bit,
  input logic final_result
);

  // an end-of-data frame always starts a flush that holds off input
  `LCLU_ASSERT(a_flush_stalls, clk, rst, (in_valid && !in_stall && end_of_data) |=> in_stall, "no stall after end of data")

  // input is only held off after a frame was taken
  `LCLU_ASSERT(a_stall_cause, clk, rst, $rose(in_stall) |-> $past(in_valid), "stall without a transfer")

  // a stalled result stays put
  `LCLU_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(latched_bit) && $stable(final_result)), "result changed under stall")

  // reset leaves no result pending
  `LCLU_ASSERT_RST(a_rst_empty, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind lookahead_confirm_latch_unit lclu_checker u_lclu_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .end_of_data  (end_of_data),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .latched_bit  (latched_bit),
  .final_result (final_result)
);
